// File: sv/pbs_pkg.sv
// ---------------------------------------------------------------------------
// pbs_pkg: shared definitions for the priority batch scheduler
// Field widths, batch size, sequencer states and the saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package pbs_pkg;

  localparam int MAX_JOBS = 32;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 6;
  localparam int TIME_W  = 21;
  localparam int TOTAL_W = 26;

  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CLK_W    = BURST_W + CNT_W;
  localparam int SUM_W    = CLK_W + CNT_W;
  localparam int SAT_W    = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
  localparam int ENTRY_W  = BURST_W + PRIO_W;
  localparam int KEY_W    = PRIO_W + IDX_W;
  localparam int ID_EXT_W = ((IDX_W + 1) > ID_W) ? (IDX_W + 1) : ID_W;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_SCAN = 4'b0010,
    S_CALC = 4'b0100,
    S_POST = 4'b1000
  } state_t;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  // Clamp a time value to the largest value of a per-job time field.
  function automatic logic [TIME_W-1:0] sat_time(input logic [SAT_W-1:0] v);
    if (v > SAT_W'({TIME_W{1'b1}})) begin
      return {TIME_W{1'b1}};
    end
    return v[TIME_W-1:0];
  endfunction

  // Clamp a running total to the largest value of a total field.
  function automatic logic [TOTAL_W-1:0] sat_total(input logic [SAT_W-1:0] v);
    if (v > SAT_W'({TOTAL_W{1'b1}})) begin
      return {TOTAL_W{1'b1}};
    end
    return v[TOTAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/pbs_ram.sv
// ---------------------------------------------------------------------------
// pbs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module pbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/priority_batch_scheduler.sv
// ---------------------------------------------------------------------------
// priority_batch_scheduler: non-preemptive priority scheduling of a batch
// Loads a batch of jobs, orders them by priority and streams the schedule.
// ---------------------------------------------------------------------------
`default_nettype none

// Jobs are taken one transfer per cycle while the block is loading; each is
// numbered by its arrival order from 1. A job flagged last, or the job that
// fills the store of MAX_JOBS entries, closes the batch and in_ready drops.
// The schedule is then built by repeated selection with a single comparator:
// for every output position the stored jobs are read back one per cycle and
// the smallest {priority, arrival} key above the previous winner is kept, so
// equal priorities leave in arrival order. Each result takes a read of every
// stored job through the job RAM port, then the last comparison, a drain
// step, the turnaround adder and the load of the result register. Once the
// final result is loaded, loading resumes even while that result still waits
// to be taken. Wait and turnaround times and their running totals are clamped
// to the largest value of their fields.

module priority_batch_scheduler
  import pbs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [BURST_W-1:0]  in_burst_time,
  input  wire logic [PRIO_W-1:0]   in_priority_level,
  input  wire logic                in_last_job,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [ID_W-1:0]          out_job_id,
  output logic [BURST_W-1:0]       out_job_burst,
  output logic [PRIO_W-1:0]        out_job_priority,
  output logic [TIME_W-1:0]        out_wait_time,
  output logic [TIME_W-1:0]        out_turnaround,
  output logic [TOTAL_W-1:0]       out_total_wait,
  output logic [TOTAL_W-1:0]       out_total_turnaround,
  output logic                     out_final_result
);

  // Sequencer and loop counters.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               best_found_r, best_found_nxt;

  // Selection and timing datapath.
  logic [KEY_W-1:0]   best_key_r, best_key_nxt;
  logic [BURST_W-1:0] best_burst_r, best_burst_nxt;
  logic [KEY_W-1:0]   last_key_r, last_key_nxt;
  logic [CLK_W-1:0]   clock_r, clock_nxt;
  logic [CLK_W-1:0]   turn_r, turn_nxt;
  logic [SUM_W-1:0]   sum_w_r, sum_w_nxt;
  logic [SUM_W-1:0]   sum_t_r, sum_t_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [ID_W-1:0]    out_id_r;
  logic [BURST_W-1:0] out_burst_r;
  logic [PRIO_W-1:0]  out_prio_r;
  logic [TIME_W-1:0]  out_wait_r;
  logic [TIME_W-1:0]  out_turn_r;
  logic [TOTAL_W-1:0] out_tw_r;
  logic [TOTAL_W-1:0] out_tt_r;
  logic               out_final_r;
  logic               out_final_nxt;
  logic [ID_EXT_W-1:0] id_ext;

  // Job store.
  logic               in_xfer;
  logic               batch_close;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic [KEY_W-1:0]   cand_key;
  logic               cand_above;
  logic               cand_better;

  assign in_ready = (state_r == S_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign batch_close = in_last_job || ((count_r + CNT_W'(1)) == CNT_W'(MAX_JOBS));

  assign wr_entry.burst = in_burst_time;
  assign wr_entry.prio  = in_priority_level;

  pbs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (rd_addr_r[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // The shared comparator: a candidate must lie above the previous winner
  // and below the best one found so far in this pass.
  assign cand_key    = {rd_entry.prio, rd_idx_r};
  assign cand_above  = (pos_r == '0) || (cand_key > last_key_r);
  assign cand_better = !best_found_r || (cand_key < best_key_r);

  assign id_ext = ID_EXT_W'(best_key_r[IDX_W-1:0]) + ID_EXT_W'(1);
  assign out_final_nxt = ((pos_r + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    rd_addr_nxt    = rd_addr_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    best_found_nxt = best_found_r;
    best_key_nxt   = best_key_r;
    best_burst_nxt = best_burst_r;
    last_key_nxt   = last_key_r;
    clock_nxt      = clock_r;
    turn_nxt       = turn_r;
    sum_w_nxt      = sum_w_r;
    sum_t_nxt      = sum_t_r;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          count_nxt = count_r + CNT_W'(1);
          if (batch_close) begin
            state_nxt      = S_SCAN;
            pos_nxt        = '0;
            rd_addr_nxt    = '0;
            best_found_nxt = 1'b0;
            clock_nxt      = '0;
            sum_w_nxt      = '0;
            sum_t_nxt      = '0;
          end
        end
      end
      S_SCAN: begin
        if (rd_addr_r != count_r) begin
          rd_addr_nxt = rd_addr_r + CNT_W'(1);
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = rd_addr_r[IDX_W-1:0];
        end
        if (rd_vld_r && cand_above && cand_better) begin
          best_found_nxt = 1'b1;
          best_key_nxt   = cand_key;
          best_burst_nxt = rd_entry.burst;
        end
        if ((rd_addr_r == count_r) && !rd_vld_r) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        turn_nxt  = clock_r + CLK_W'(best_burst_r);
        sum_w_nxt = sum_w_r + SUM_W'(clock_r);
        state_nxt = S_POST;
      end
      S_POST: begin
        // Wait here until the result register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          out_load       = 1'b1;
          out_valid_nxt  = 1'b1;
          sum_t_nxt      = sum_t_r + SUM_W'(turn_r);
          clock_nxt      = turn_r;
          last_key_nxt   = best_key_r;
          pos_nxt        = pos_r + CNT_W'(1);
          rd_addr_nxt    = '0;
          best_found_nxt = 1'b0;
          if (out_final_nxt) begin
            state_nxt = S_LOAD;
            count_nxt = '0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      count_r      <= '0;
      pos_r        <= '0;
      rd_addr_r    <= '0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pos_r        <= pos_nxt;
      rd_addr_r    <= rd_addr_nxt;
      rd_vld_r     <= rd_vld_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers; each batch initialises what it uses when it closes.
  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    best_key_r   <= best_key_nxt;
    best_burst_r <= best_burst_nxt;
    last_key_r   <= last_key_nxt;
    clock_r      <= clock_nxt;
    turn_r       <= turn_nxt;
    sum_w_r      <= sum_w_nxt;
    sum_t_r      <= sum_t_nxt;
    if (out_load) begin
      out_id_r    <= id_ext[ID_W-1:0];
      out_burst_r <= best_burst_r;
      out_prio_r  <= best_key_r[KEY_W-1:IDX_W];
      out_wait_r  <= sat_time(SAT_W'(clock_r));
      out_turn_r  <= sat_time(SAT_W'(turn_r));
      out_tw_r    <= sat_total(SAT_W'(sum_w_r));
      out_tt_r    <= sat_total(SAT_W'(sum_t_nxt));
      out_final_r <= out_final_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_job_id           = out_id_r;
  assign out_job_burst        = out_burst_r;
  assign out_job_priority     = out_prio_r;
  assign out_wait_time        = out_wait_r;
  assign out_turnaround       = out_turn_r;
  assign out_total_wait       = out_tw_r;
  assign out_total_turnaround = out_tt_r;
  assign out_final_result     = out_final_r;

  // An unclamped turnaround is always the wait time plus the job's own burst.
  a_turn_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_turn_r != {TIME_W{1'b1}})) |->
      ((22'(out_wait_r) + 22'(out_burst_r)) == 22'(out_turn_r)))
    else $error("turnaround does not equal wait time plus burst");

  // The output position never runs past the number of jobs in the batch.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (pos_r < count_r))
    else $error("schedule position beyond batch size");

  // Every selection pass must have found a winner before its result is built.
  a_winner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POST) |-> best_found_r)
    else $error("selection pass ended without a winner");

  // The job count never exceeds the store depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_JOBS))
    else $error("job count beyond store depth");

endmodule

`default_nettype wire
